[hdl/dtp_pkg.sv]
// Shared constants, types and sine table builders for the depth to point projection block.
package dtp_pkg;

   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;

   localparam int COL_W    = $clog2(IMAGE_WIDTH);
   localparam int ROW_W    = $clog2(IMAGE_HEIGHT);
   localparam int DEPTH_W  = 16;
   localparam int COORD_W  = 16;
   localparam int COUNT_W  = 19;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]    COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [DEPTH_W-1:0]    MIN_DEPTH_RST = 16'd500;
   localparam logic [DEPTH_W-1:0]    MAX_DEPTH_RST = 16'd8000;

   // Full field of view in radians, Q2.30, from tenths of a degree and pi as 3.14159.
   localparam logic [63:0] K_H = (64'd585 * 64'd314159 * (64'd1 << 30) + 64'd90000000)
                                 / 64'd180000000;
   localparam logic [63:0] K_V = (64'd466 * 64'd314159 * (64'd1 << 30) + 64'd90000000)
                                 / 64'd180000000;
   localparam logic [63:0] COL_SIZE = 64'(IMAGE_WIDTH);
   localparam logic [63:0] ROW_SIZE = 64'(IMAGE_HEIGHT);
   localparam logic [63:0] COL_DIV  = 64'(2 * IMAGE_WIDTH);
   localparam logic [63:0] ROW_DIV  = 64'(2 * IMAGE_HEIGHT);

   typedef enum logic [0:0] {
      CSR_MIN_DEPTH = 1'b0,
      CSR_MAX_DEPTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               point_valid;
      logic [DEPTH_W-1:0] z_mm;
      logic [COUNT_W-1:0] valid_count;
      logic               frame_done;
   } pipe_info_type;

   typedef logic signed [COORD_W-1:0] col_table_type [IMAGE_WIDTH];
   typedef logic signed [COORD_W-1:0] row_table_type [IMAGE_HEIGHT];

   // Taylor series of sine to the ninth power, Q2.30 in, Q1.15 out with sign applied.
   function automatic logic signed [COORD_W-1:0] sine_q15(input logic [63:0] a,
                                                          input logic neg);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] q;
      x2   = (a * a) >> 30;
      term = a;
      sum  = a;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      q    = (sum + 64'd16384) >> 15;
      return neg ? COORD_W'(-q) : COORD_W'(q);
   endfunction

   function automatic col_table_type build_col_table();
      col_table_type tbl;
      logic [63:0]   twice;
      logic [63:0]   mag;
      logic [63:0]   a;
      logic          neg;
      for (int i = 0; i < IMAGE_WIDTH; i++) begin
         twice  = 64'(2 * i);
         neg    = twice < COL_SIZE;
         mag    = neg ? COL_SIZE - twice : twice - COL_SIZE;
         a      = (mag * K_H + COL_SIZE) / COL_DIV;
         tbl[i] = sine_q15(a, neg);
      end
      return tbl;
   endfunction

   function automatic row_table_type build_row_table();
      row_table_type tbl;
      logic [63:0]   twice;
      logic [63:0]   mag;
      logic [63:0]   a;
      logic          neg;
      for (int i = 0; i < IMAGE_HEIGHT; i++) begin
         twice  = 64'(2 * i);
         neg    = twice < ROW_SIZE;
         mag    = neg ? ROW_SIZE - twice : twice - ROW_SIZE;
         a      = (mag * K_V + ROW_SIZE) / ROW_DIV;
         tbl[i] = sine_q15(a, neg);
      end
      return tbl;
   endfunction

endpackage

[hdl/dtp_if.sv]
// Handshake interfaces for the depth sample and point result channels.
interface dtp_req_if;
   import dtp_pkg::*;
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_mm;
   modport source (output valid, output depth_mm, input ready);
   modport sink   (input valid, input depth_mm, output ready);
endinterface

interface dtp_rsp_if;
   import dtp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      point_valid;
   logic signed [COORD_W-1:0] x_mm;
   logic signed [COORD_W-1:0] y_mm;
   logic [DEPTH_W-1:0]        z_mm;
   logic [COUNT_W-1:0]        valid_count;
   logic                      frame_done;
   modport source (output valid, output point_valid, output x_mm, output y_mm,
                   output z_mm, output valid_count, output frame_done, input ready);
   modport sink   (input valid, input point_valid, input x_mm, input y_mm,
                   input z_mm, input valid_count, input frame_done, output ready);
endinterface

[hdl/dtp_frame_ctrl.sv]
// Depth thresholds, raster counters and point counting at item acceptance.
module dtp_frame_ctrl
   import dtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  accept,
   input  logic [DEPTH_W-1:0]    depth_mm,
   output logic [COL_W-1:0]      col_addr,
   output logic [ROW_W-1:0]      row_addr,
   output pipe_info_type         info
);

   logic [DEPTH_W-1:0] min_ff;
   logic [DEPTH_W-1:0] max_ff;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_next;
   pipe_info_type      info_ff;
   pipe_info_type      info_in;
   logic               in_range;
   logic               last_col;
   logic               last_row;

   assign col_addr = col_ff;
   assign row_addr = row_ff;
   assign info     = info_ff;

   always_comb begin
      in_range   = (depth_mm > min_ff) && (depth_mm < max_ff);
      last_col   = col_ff == COL_W'(IMAGE_WIDTH - 1);
      last_row   = row_ff == ROW_W'(IMAGE_HEIGHT - 1);
      count_next = (in_range && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

      info_in.point_valid = in_range;
      info_in.z_mm        = in_range ? depth_mm : '0;
      info_in.valid_count = count_next;
      info_in.frame_done  = last_col && last_row;

      col_in   = last_col ? '0 : col_ff + 1'b1;
      row_in   = last_col ? (last_row ? '0 : row_ff + 1'b1) : row_ff;
      count_in = (last_col && last_row) ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_DEPTH_RST;
         max_ff   <= MAX_DEPTH_RST;
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_DEPTH: min_ff <= csr_wdata;
               CSR_MAX_DEPTH: max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info_in;
      end
   end

endmodule

[hdl/dtp_sine_rom.sv]
// Column and row sine tables in Q1.15 as synchronous read-only memories.
module dtp_sine_rom
   import dtp_pkg::*;
(
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [COL_W-1:0]          col_addr,
   input  logic [ROW_W-1:0]          row_addr,
   output logic signed [COORD_W-1:0] col_sine,
   output logic signed [COORD_W-1:0] row_sine
);

   localparam col_table_type COL_SINE = build_col_table();
   localparam row_table_type ROW_SINE = build_row_table();

   logic signed [COORD_W-1:0] col_sine_ff;
   logic signed [COORD_W-1:0] row_sine_ff;

   assign col_sine = col_sine_ff;
   assign row_sine = row_sine_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         col_sine_ff <= COL_SINE[col_addr];
         row_sine_ff <= ROW_SINE[row_addr];
      end
   end

endmodule

[hdl/dtp_scale.sv]
// Depth times sine with rounding to nearest and signed saturation, two register stages.
module dtp_scale
   import dtp_pkg::*;
(
   input  logic                      clock,
   input  logic                      mul_en,
   input  logic                      out_en,
   input  logic [DEPTH_W-1:0]        z_mm,
   input  logic signed [COORD_W-1:0] sine,
   output logic signed [COORD_W-1:0] coord
);

   logic [COORD_W-1:0]         sine_mag;
   logic [DEPTH_W+COORD_W-1:0] prod_ff;
   logic [DEPTH_W+COORD_W-1:0] prod_in;
   logic                       neg_ff;
   logic [DEPTH_W+COORD_W-1:0] rounded;
   logic [16:0]                mag;
   logic signed [COORD_W-1:0]  coord_ff;
   logic signed [COORD_W-1:0]  coord_in;

   assign coord = coord_ff;

   always_comb begin
      sine_mag = sine[COORD_W-1] ? COORD_W'(-sine) : sine;
      prod_in  = (DEPTH_W+COORD_W)'(z_mm) * (DEPTH_W+COORD_W)'(sine_mag);
      rounded  = prod_ff + (DEPTH_W+COORD_W)'(16384);
      mag      = rounded[31:15];
      // The negative side reaches one step further than the positive side.
      if (neg_ff) begin
         coord_in = (mag > 17'd32768) ? 16'sh8000 : COORD_W'(-mag[15:0]);
      end else begin
         coord_in = (mag > 17'd32767) ? 16'sh7FFF : mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         neg_ff  <= sine[COORD_W-1];
      end
      if (out_en) begin
         coord_ff <= coord_in;
      end
   end

endmodule

[hdl/depth_to_point_projection_top.sv]
// Depth to point projection: turns raster-order depth samples into x, y, z points.
// The req channel takes one depth sample per item in raster order, columns first.
// The rsp channel returns exactly one item per sample: point_valid, x_mm, y_mm, z_mm,
// the running count of in-range points of the frame and a flag on the frame's last pixel.
// The csr port sets the exclusive lower (index 0) and upper (index 1) depth bounds.
// One item is taken every cycle while the receiver does not stall.
// The three stages are the registered sine table read, the multiplier and the
// rounding and saturation output register.
// Reset clears the raster and point counters and loads bounds of 500 and 8000 mm.
// The sine tables are constant, so the block takes items in the first cycle after reset.
// When the receiver stalls, each stage holds its item and empty stages ahead still
// fill, so req stays ready until all three stages are full.
module depth_to_point_projection_top
   import dtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dtp_req_if.sink               req_chan,
   dtp_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                      v1_ff;
   logic                      v2_ff;
   logic                      v3_ff;
   logic                      en1;
   logic                      en2;
   logic                      en3;
   logic                      accept;
   logic [COL_W-1:0]          col_addr;
   logic [ROW_W-1:0]          row_addr;
   pipe_info_type             info1;
   pipe_info_type             info2_ff;
   pipe_info_type             info3_ff;
   logic signed [COORD_W-1:0] col_sine;
   logic signed [COORD_W-1:0] row_sine;
   logic signed [COORD_W-1:0] x_mm;
   logic signed [COORD_W-1:0] y_mm;

   assign en3    = !v3_ff || rsp_chan.ready;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_chan.valid && en1;

   assign req_chan.ready = en1;

   dtp_frame_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .depth_mm  (req_chan.depth_mm),
      .col_addr  (col_addr),
      .row_addr  (row_addr),
      .info      (info1)
   );

   dtp_sine_rom u_rom (
      .clock    (clock),
      .rd_en    (accept),
      .col_addr (col_addr),
      .row_addr (row_addr),
      .col_sine (col_sine),
      .row_sine (row_sine)
   );

   dtp_scale u_scale_x (
      .clock  (clock),
      .mul_en (en2),
      .out_en (en3),
      .z_mm   (info1.z_mm),
      .sine   (col_sine),
      .coord  (x_mm)
   );

   dtp_scale u_scale_y (
      .clock  (clock),
      .mul_en (en2),
      .out_en (en3),
      .z_mm   (info1.z_mm),
      .sine   (row_sine),
      .coord  (y_mm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) info2_ff <= info1;
      if (en3) info3_ff <= info2_ff;
   end

   assign rsp_chan.valid       = v3_ff;
   assign rsp_chan.point_valid = info3_ff.point_valid;
   assign rsp_chan.x_mm        = x_mm;
   assign rsp_chan.y_mm        = y_mm;
   assign rsp_chan.z_mm        = info3_ff.z_mm;
   assign rsp_chan.valid_count = info3_ff.valid_count;
   assign rsp_chan.frame_done  = info3_ff.frame_done;

endmodule

[dv/tb_depth_to_point_projection_top.sv]
// Self-checking testbench for the depth to point projection block with a built-in predictor.
`timescale 1ns / 100ps

module tb_depth_to_point_projection_top;
   import dtp_pkg::*;

   localparam int DIRECTED_ROWS = 26;
   localparam int STREAM_ITEMS = 60;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 155;
   localparam int MAX_GAP = 6;
   localparam int HOLD_CYCLES = 48;
   localparam int DRAIN_LIMIT = 2000;

   typedef struct packed {
      logic                      point_valid;
      logic signed [COORD_W-1:0] x_mm;
      logic signed [COORD_W-1:0] y_mm;
      logic [DEPTH_W-1:0]        z_mm;
      logic [COUNT_W-1:0]        valid_count;
      logic                      frame_done;
   } projected_point_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   // A row either writes a bound or sends a depth; rejected samples carry their
   // expected count directly, everything else goes through the predictor.
   typedef struct packed {
      row_kind_type       kind;
      csr_index_type      reg_sel;
      logic [DEPTH_W-1:0] value;
      logic               rejected;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dtp_req_if req_chan ();
   dtp_rsp_if rsp_chan ();

   depth_to_point_projection_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd0,     1'b1, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd500,   1'b1, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd8000,  1'b1, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd65535, 1'b1, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd501,   1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd7999,  1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'hAAAA,  1'b1, 19'd2},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'h5555,  1'b1, 19'd2},
      '{ROW_WRITE,  CSR_MIN_DEPTH, 16'd0,     1'b0, 19'd0},
      '{ROW_WRITE,  CSR_MAX_DEPTH, 16'd65535, 1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd0,     1'b1, 19'd2},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd65535, 1'b1, 19'd2},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd1,     1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd65534, 1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd32768, 1'b0, 19'd0},
      '{ROW_WRITE,  CSR_MIN_DEPTH, 16'd9000,  1'b0, 19'd0},
      '{ROW_WRITE,  CSR_MAX_DEPTH, 16'd100,   1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd5000,  1'b1, 19'd5},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd9001,  1'b1, 19'd5},
      '{ROW_WRITE,  CSR_MIN_DEPTH, 16'd100,   1'b0, 19'd0},
      '{ROW_WRITE,  CSR_MAX_DEPTH, 16'd101,   1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd100,   1'b1, 19'd5},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd101,   1'b1, 19'd5},
      '{ROW_WRITE,  CSR_MAX_DEPTH, 16'd102,   1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd101,   1'b0, 19'd0},
      '{ROW_SAMPLE, CSR_MIN_DEPTH, 16'd102,   1'b1, 19'd6}
   };

   // Predictor state: sine tables, bounds and raster position.
   int col_sine_q15 [IMAGE_WIDTH];
   int row_sine_q15 [IMAGE_HEIGHT];
   logic [DEPTH_W-1:0] lower_bound;
   logic [DEPTH_W-1:0] upper_bound;
   logic [COL_W-1:0]   raster_col;
   logic [ROW_W-1:0]   raster_row;
   logic [COUNT_W-1:0] frame_points;

   projected_point_type expected_points [$];
   int mismatches;
   int samples_sent;
   int results_seen;
   int points_seen;
   int frames_seen;
   bit no_idle;
   bit hold_rsp;

   // Angle is (2i - size) / (2 size) of the field of view, sine by a five-term series.
   function automatic int fov_sine_q15(int idx, int size, longint unsigned fov_tenths);
      longint unsigned full_rad;
      longint unsigned span;
      longint unsigned ang;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned acc;
      int q;
      bit below;
      full_rad = (fov_tenths * 64'd314159 * (64'd1 << 30) + 64'd90000000) / 64'd180000000;
      below = 2 * idx < size;
      span = below ? longint'(size - 2 * idx) : longint'(2 * idx - size);
      ang = (span * full_rad + longint'(size)) / longint'(2 * size);
      sq = (ang * ang) >> 30;
      term = ang;
      acc = ang;
      for (int n = 1; n <= 4; n++) begin
         term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
         acc = (n % 2 == 1) ? acc - term : acc + term;
      end
      q = int'((acc + 64'd16384) >> 15);
      return below ? -q : q;
   endfunction

   function automatic logic signed [COORD_W-1:0] scale_to_mm(logic [DEPTH_W-1:0] z, int s);
      longint mag;
      longint v;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      v = (longint'(z) * mag + 16384) >> 15;
      if (s < 0)
         v = -v;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return COORD_W'(v);
   endfunction

   function automatic projected_point_type project_sample(logic [DEPTH_W-1:0] depth);
      projected_point_type p;
      logic in_range;
      logic last_col;
      logic last_row;
      in_range = depth > lower_bound && depth < upper_bound;
      if (in_range && frame_points != COUNT_MAX)
         frame_points = frame_points + 1'b1;
      p.point_valid = in_range;
      p.x_mm = in_range ? scale_to_mm(depth, col_sine_q15[raster_col]) : '0;
      p.y_mm = in_range ? scale_to_mm(depth, row_sine_q15[raster_row]) : '0;
      p.z_mm = in_range ? depth : '0;
      p.valid_count = frame_points;
      last_col = raster_col == COL_W'(IMAGE_WIDTH - 1);
      last_row = raster_row == ROW_W'(IMAGE_HEIGHT - 1);
      p.frame_done = last_col && last_row;
      if (last_col) begin
         raster_col = '0;
         raster_row = last_row ? '0 : raster_row + 1'b1;
      end else begin
         raster_col = raster_col + 1'b1;
      end
      if (p.frame_done)
         frame_points = '0;
      return p;
   endfunction

   // Offers one depth item after a random gap, or none when no_idle is set, and records its expected point.
   task automatic offer_depth(logic [DEPTH_W-1:0] depth, logic rejected,
                              logic [COUNT_W-1:0] count);
      projected_point_type p;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.depth_mm <= depth;
      do @(posedge clock); while (!req_chan.ready);
      p = project_sample(depth);
      if (rejected) begin
         p = '0;
         p.valid_count = count;
      end
      expected_points.push_back(p);
      samples_sent++;
   endtask

   // Leaves csr_we high; the caller lowers it after the last write of a group.
   task automatic write_bound(csr_index_type sel, logic [DEPTH_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      if (sel == CSR_MIN_DEPTH)
         lower_bound = value;
      else
         upper_bound = value;
      @(posedge clock);
   endtask

   task automatic program_bounds(logic [DEPTH_W-1:0] lo, logic [DEPTH_W-1:0] hi);
      write_bound(CSR_MIN_DEPTH, lo);
      write_bound(CSR_MAX_DEPTH, hi);
      csr_we <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls, one long hold when asked, and the field compare.
   initial begin
      projected_point_type want;
      projected_point_type got;
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.point_valid = rsp_chan.point_valid;
         got.x_mm = rsp_chan.x_mm;
         got.y_mm = rsp_chan.y_mm;
         got.z_mm = rsp_chan.z_mm;
         got.valid_count = rsp_chan.valid_count;
         got.frame_done = rsp_chan.frame_done;
         results_seen++;
         if (got.point_valid)
            points_seen++;
         if (got.frame_done)
            frames_seen++;
         if (expected_points.size() == 0) begin
            $error("unexpected point item: x_mm %0d y_mm %0d z_mm %0d",
                   got.x_mm, got.y_mm, got.z_mm);
            mismatches++;
         end else begin
            want = expected_points.pop_front();
            if (got.point_valid !== want.point_valid) begin
               $error("point_valid: expected %0d, got %0d", want.point_valid, got.point_valid);
               mismatches++;
            end
            if (got.x_mm !== want.x_mm) begin
               $error("x_mm: expected %0d, got %0d", want.x_mm, got.x_mm);
               mismatches++;
            end
            if (got.y_mm !== want.y_mm) begin
               $error("y_mm: expected %0d, got %0d", want.y_mm, got.y_mm);
               mismatches++;
            end
            if (got.z_mm !== want.z_mm) begin
               $error("z_mm: expected %0d, got %0d", want.z_mm, got.z_mm);
               mismatches++;
            end
            if (got.valid_count !== want.valid_count) begin
               $error("valid_count: expected %0d, got %0d", want.valid_count, got.valid_count);
               mismatches++;
            end
            if (got.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int lo;
      int hi;
      int v;
      int waited;
      for (int i = 0; i < IMAGE_WIDTH; i++)
         col_sine_q15[i] = fov_sine_q15(i, IMAGE_WIDTH, 64'd585);
      for (int i = 0; i < IMAGE_HEIGHT; i++)
         row_sine_q15[i] = fov_sine_q15(i, IMAGE_HEIGHT, 64'd466);
      lower_bound = MIN_DEPTH_RST;
      upper_bound = MAX_DEPTH_RST;
      raster_col = '0;
      raster_row = '0;
      frame_points = '0;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.depth_mm <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_MIN_DEPTH;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_table[r].kind == ROW_WRITE) begin
            write_bound(directed_table[r].reg_sel, directed_table[r].value);
            if (r + 1 == DIRECTED_ROWS || directed_table[r + 1].kind != ROW_WRITE)
               csr_we <= 1'b0;
         end else begin
            offer_depth(directed_table[r].value, directed_table[r].rejected,
                        directed_table[r].count);
         end
      end

      // Stream back to back with wide bounds.
      program_bounds(16'd200, 16'd60000);
      no_idle = 1'b1;
      for (int n = 0; n < STREAM_ITEMS; n++)
         offer_depth(DEPTH_W'($urandom_range(0, 65535)), 1'b0, '0);
      no_idle = 1'b0;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               lo = 0;
               hi = 65535;
            end
            1: begin
               lo = $urandom_range(0, 30000);
               hi = $urandom_range(lo + 2, 65535);
            end
            2: begin
               lo = $urandom_range(0, 65000);
               hi = lo + $urandom_range(2, 40);
            end
            3: begin
               lo = MIN_DEPTH_RST;
               hi = MAX_DEPTH_RST;
            end
            default: begin
               lo = $urandom_range(0, 65535);
               hi = $urandom_range(0, 65535);
            end
         endcase
         program_bounds(DEPTH_W'(lo), DEPTH_W'(hi));
         if (ph == 0)
            hold_rsp = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            no_idle = (ph == 0 && n < 60) || ((n / 40) % 3 == 2);
            case ($urandom_range(0, 9))
               0, 1: v = $urandom_range(0, 65535);
               2, 3: v = lo + $urandom_range(0, 6) - 3;
               4, 5: v = hi + $urandom_range(0, 6) - 3;
               default: v = (lo < hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
            endcase
            if (v < 0)
               v = 0;
            if (v > 65535)
               v = 65535;
            offer_depth(DEPTH_W'(v), 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d expected point items never arrived", expected_points.size());
         mismatches += expected_points.size();
      end
      $display("Projected %0d depth items, %0d of them in range, across %0d finished frame(s).",
               results_seen, points_seen, frames_seen);
      $display("Bounds covered defaults, full, narrow, empty and inverted ranges.");
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
hdl/dtp_pkg.sv
hdl/dtp_if.sv
hdl/dtp_frame_ctrl.sv
hdl/dtp_sine_rom.sv
hdl/dtp_scale.sv
hdl/depth_to_point_projection_top.sv
dv/tb_depth_to_point_projection_top.sv
